// ===== rtl/core/ura_pkg.sv =====
package ura_pkg;

	// fixed field widths
	localparam int IN_W        = 64;
	localparam int RADIX_W     = 6;
	localparam int DIGIT_W     = 6;
	localparam int CHAR_W      = 7;
	localparam int TOTAL_W     = 7;
	localparam int OUT_TDATA_W = 16;

	// default value width
	localparam int VALUE_BITS_DEF = 64;

	// radix register limits and reset value
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

	// character codes
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;
	localparam logic [CHAR_W-1:0] DEC_TEN    = 7'd10;

	// remainder to character: 0..9 then A..Z
	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {1'b0, d};
		if (dx < DEC_TEN)
			return dx + ASCII_ZERO;
		else
			return dx - DEC_TEN + ASCII_A;
	endfunction

endpackage

// ===== rtl/core/unsigned_to_radix_ascii.sv =====
// Channel  Dir  Handshake         Payload
// s_*      in   tvalid/tready     tdata[63:0] number
// m_*      out  tvalid/tready     tdata[6:0] digit_char, [13:7] digit_total; tlast final_digit
// cfg_*    in   cfg_wen           cfg_wdata[5:0] radix (2..36 taken, others ignored)
//
// Each digit comes from one pass of the bit-serial restoring divider over VALUE_BITS
// bits, one quotient bit per cycle; a value with D digits takes D passes to convert.
// Each character is then read from the digit store (ST_RD) and presented in ST_OUT until taken.
// Example: 64-bit value, radix 10: up to 20 digits.
// arst_n clears state and sets radix to 10; the digit store is not cleared.
// One transaction in flight: s_tready is low from acceptance until the last character leaves.
module unsigned_to_radix_ascii #(
	parameter int VALUE_BITS = ura_pkg::VALUE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [ura_pkg::RADIX_W-1:0]      cfg_wdata,  // radix
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ura_pkg::IN_W-1:0]         s_tdata,    // number
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ura_pkg::OUT_TDATA_W-1:0]  m_tdata,    // digit_char, digit_total, zero pad
	output logic                             m_tlast     // final_digit
);
	import ura_pkg::*;

	localparam int AW = $clog2(VALUE_BITS);
	localparam int CW = $clog2(VALUE_BITS + 1);
	localparam logic [AW-1:0] BIT_LAST = AW'(VALUE_BITS - 1);
	localparam int PAD_W = OUT_TDATA_W - CHAR_W - TOTAL_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]            state_q;
	logic [RADIX_W-1:0]    radix_q;
	logic [VALUE_BITS-1:0] quot_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic                  nz_q;
	logic [AW-1:0]         bit_q;
	logic [CW-1:0]         cnt_q;
	logic [AW-1:0]         rd_ptr_q;
	logic [DIGIT_W-1:0]    rd_data_q;
	logic [DIGIT_W-1:0]    store_mem [VALUE_BITS];

	logic                  s_acc;
	logic                  m_acc;
	logic [DIGIT_W:0]      trial;
	logic [DIGIT_W:0]      trial_sub;
	logic                  ge;
	logic [DIGIT_W-1:0]    rem_next;
	logic                  nz_next;
	logic                  bit_last;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	// one restoring division step: bring down the next quotient bit
	always_comb begin
		trial     = {rem_q, quot_q[VALUE_BITS-1]};
		trial_sub = trial - {1'b0, radix_q};
		ge        = (trial >= {1'b0, radix_q});
		rem_next  = ge ? trial_sub[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
		nz_next   = nz_q || ge;
		bit_last  = (bit_q == BIT_LAST);
	end

	// radix register, out-of-range writes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_wen && cfg_wdata >= RADIX_MIN && cfg_wdata <= RADIX_MAX) begin
			radix_q <= cfg_wdata;
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			nz_q     <= 1'b0;
			bit_q    <= '0;
			cnt_q    <= '0;
			rd_ptr_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= ST_DIV;
						nz_q    <= 1'b0;
						bit_q   <= '0;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (bit_last) begin
						cnt_q <= cnt_q + CW'(1);
						bit_q <= '0;
						nz_q  <= 1'b0;
						if (!nz_next) begin
							// quotient is zero: this was the top digit
							state_q  <= ST_RD;
							rd_ptr_q <= cnt_q[AW-1:0];
						end
					end else begin
						bit_q <= bit_q + AW'(1);
						nz_q  <= nz_next;
					end
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_acc) begin
						if (rd_ptr_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rd_ptr_q <= rd_ptr_q - AW'(1);
							state_q  <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// quotient and remainder shift registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			quot_q <= s_tdata[VALUE_BITS-1:0];
			rem_q  <= '0;
		end else if (state_q == ST_DIV) begin
			quot_q <= {quot_q[VALUE_BITS-2:0], ge};
			rem_q  <= bit_last ? '0 : rem_next;
		end
	end

	// digit store, registered read
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && bit_last)
			store_mem[cnt_q[AW-1:0]] <= rem_next;
		if (state_q == ST_RD)
			rd_data_q <= store_mem[rd_ptr_q];
	end

	// ports
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {{PAD_W{1'b0}}, TOTAL_W'(cnt_q), digit_ascii(rd_data_q)};
	assign m_tlast  = (rd_ptr_q == '0);

	// checks
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output sides active together");

	a_radix_range: assert property (@(posedge clk) disable iff (!arst_n)
		radix_q >= RADIX_MIN && radix_q <= RADIX_MAX)
		else $error("radix register out of range");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> (state_q == ST_DIV) && (cnt_q == '0) && (bit_q == '0))
		else $error("conversion did not start cleanly");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_OUT) |-> (CW'(rd_ptr_q) < cnt_q))
		else $error("read pointer beyond digit count");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_acc && m_tlast) |=> (state_q == ST_IDLE))
		else $error("no return to idle after final character");

endmodule
